@@ hdl/dimg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dimg_pkg
// Shared widths, event codes and word layout for the disk image track parser.
// ----------------------------------------------------------------------------
package dimg_pkg;

    // field widths
    localparam int BYTE_W   = 8;
    localparam int EVENT_W  = 3;
    localparam int HEAD_W   = 6;
    localparam int SBYTES_W = 14;
    localparam int OFFSET_W = 13;
    localparam int PHASE_W  = 4;
    localparam int SIZE_W   = 3;

    // result word layout, lowest bit first
    localparam int MODE_LO   = 0;
    localparam int CYL_LO    = MODE_LO + BYTE_W;
    localparam int HEAD_LO   = CYL_LO + BYTE_W;
    localparam int COUNT_LO  = HEAD_LO + HEAD_W;
    localparam int SBYTES_LO = COUNT_LO + BYTE_W;
    localparam int INDEX_LO  = SBYTES_LO + SBYTES_W;
    localparam int OFFSET_LO = INDEX_LO + BYTE_W;
    localparam int VALUE_LO  = OFFSET_LO + OFFSET_W;
    localparam int USED_W    = VALUE_LO + BYTE_W;
    localparam int M_DATA_W  = ((USED_W + 7) / 8) * 8;

    // event kinds
    localparam logic [EVENT_W-1:0] EV_HEADER  = 3'd0;
    localparam logic [EVENT_W-1:0] EV_SECMAP  = 3'd1;
    localparam logic [EVENT_W-1:0] EV_CYLMAP  = 3'd2;
    localparam logic [EVENT_W-1:0] EV_HEADMAP = 3'd3;
    localparam logic [EVENT_W-1:0] EV_DATA    = 3'd4;
    localparam logic [EVENT_W-1:0] EV_FILL    = 3'd5;
    localparam logic [EVENT_W-1:0] EV_ABSENT  = 3'd6;
    localparam logic [EVENT_W-1:0] EV_ERROR   = 3'd7;

    // stream markers, head flag bits, largest size code and base sector size
    localparam logic [BYTE_W-1:0] COMMENT_END   = 8'h1a;
    localparam logic [BYTE_W-1:0] TYPE_ABSENT   = 8'h00;
    localparam logic [BYTE_W-1:0] TYPE_FILL     = 8'h02;
    localparam int                CYLMAP_BIT    = 7;
    localparam int                HEADMAP_BIT   = 6;
    localparam logic [BYTE_W-1:0] LARGEST_SIZE  = 8'd6;
    localparam logic [SBYTES_W-1:0] BASE_SECTOR = 14'd128;

endpackage

@@ hdl/disk_image_track_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disk_image_track_parser
// Walks an image file byte stream: skips the text comment, then decodes track
// records into header, map, data, fill, absent and error event words.
// ----------------------------------------------------------------------------
// The result word is registered and appears in the cycle after its input word is accepted.
// Throughput: one input word per cycle; s_tready drops only while a result
// waits in the output register and m_tready is low.
// Reset: aresetn (synchronous, active low) returns to comment skipping and
// clears the track fields, counters and output valid.
module disk_image_track_parser #(
    parameter int MAX_SIZE_CODE = 6
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [dimg_pkg::BYTE_W-1:0]      s_tdata,   // byte_value
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // mode_code, cylinder, head_number, sector_count, sector_bytes,
    // sector_index, byte_offset, item_value, zero padding
    output logic [dimg_pkg::M_DATA_W-1:0]    m_tdata,
    output logic [dimg_pkg::EVENT_W-1:0]     m_tuser,   // event_res
    output logic                             m_tlast    // track_last
);
    import dimg_pkg::*;

    localparam logic [BYTE_W-1:0] MAX_CODE = BYTE_W'(MAX_SIZE_CODE);

    // phase codes
    localparam logic [PHASE_W-1:0] PH_COMMENT = 4'd0;
    localparam logic [PHASE_W-1:0] PH_MODE    = 4'd1;
    localparam logic [PHASE_W-1:0] PH_CYL     = 4'd2;
    localparam logic [PHASE_W-1:0] PH_HEAD    = 4'd3;
    localparam logic [PHASE_W-1:0] PH_NSEC    = 4'd4;
    localparam logic [PHASE_W-1:0] PH_SIZE    = 4'd5;
    localparam logic [PHASE_W-1:0] PH_SECMAP  = 4'd6;
    localparam logic [PHASE_W-1:0] PH_CYLMAP  = 4'd7;
    localparam logic [PHASE_W-1:0] PH_HEADMAP = 4'd8;
    localparam logic [PHASE_W-1:0] PH_TYPE    = 4'd9;
    localparam logic [PHASE_W-1:0] PH_FILL    = 4'd10;
    localparam logic [PHASE_W-1:0] PH_DATA    = 4'd11;
    localparam logic [PHASE_W-1:0] PH_HALT    = 4'd12;

    // parser state
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic [BYTE_W-1:0]   mode_reg, mode_next;
    logic [BYTE_W-1:0]   cyl_reg, cyl_next;
    logic [BYTE_W-1:0]   hflags_reg, hflags_next;
    logic [BYTE_W-1:0]   nsec_reg, nsec_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [BYTE_W-1:0]   entry_reg, entry_next;
    logic [OFFSET_W-1:0] bcnt_reg, bcnt_next;

    // output register
    logic                m_valid_reg;
    logic [EVENT_W-1:0]  m_user_reg;
    logic [M_DATA_W-1:0] m_data_reg;
    logic                m_last_reg;

    // result of the current word
    logic                emit;
    logic [EVENT_W-1:0]  ev;
    logic [SBYTES_W-1:0] ev_sbytes;
    logic [BYTE_W-1:0]   ev_index;
    logic [OFFSET_W-1:0] ev_offset;
    logic [BYTE_W-1:0]   ev_value;
    logic                ev_last;

    logic                accept;
    logic [SBYTES_W-1:0] sec_bytes;
    logic                entry_end;
    logic                sector_end;
    logic [SBYTES_W-1:0] bcnt_inc;
    logic [PHASE_W-1:0]  map_follow;

    assign s_tready  = !m_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign sec_bytes = BASE_SECTOR << size_reg;
    assign entry_end = entry_reg >= (nsec_reg - 8'd1);
    assign bcnt_inc  = {1'b0, bcnt_reg} + 14'd1;
    assign sector_end = bcnt_inc >= sec_bytes;

    // next phase after the last entry of the current map
    always_comb begin
        if (phase_reg == PH_SECMAP && hflags_reg[CYLMAP_BIT]) begin
            map_follow = PH_CYLMAP;
        end else if ((phase_reg == PH_SECMAP || phase_reg == PH_CYLMAP)
                     && hflags_reg[HEADMAP_BIT]) begin
            map_follow = PH_HEADMAP;
        end else begin
            map_follow = PH_TYPE;
        end
    end

    // phase machine and event decode
    always_comb begin
        phase_next  = phase_reg;
        mode_next   = mode_reg;
        cyl_next    = cyl_reg;
        hflags_next = hflags_reg;
        nsec_next   = nsec_reg;
        size_next   = size_reg;
        entry_next  = entry_reg;
        bcnt_next   = bcnt_reg;
        emit        = 1'b0;
        ev          = EV_HEADER;
        ev_sbytes   = sec_bytes;
        ev_index    = entry_reg;
        ev_offset   = '0;
        ev_value    = s_tdata;
        ev_last     = 1'b0;
        case (phase_reg)
            PH_COMMENT: begin
                if (s_tdata == COMMENT_END) begin
                    phase_next = PH_MODE;
                end
            end
            PH_MODE: begin
                mode_next  = s_tdata;
                phase_next = PH_CYL;
            end
            PH_CYL: begin
                cyl_next   = s_tdata;
                phase_next = PH_HEAD;
            end
            PH_HEAD: begin
                hflags_next = s_tdata;
                phase_next  = PH_NSEC;
            end
            PH_NSEC: begin
                nsec_next  = s_tdata;
                phase_next = PH_SIZE;
            end
            PH_SIZE: begin
                emit     = 1'b1;
                ev_index = '0;
                if (s_tdata > MAX_CODE || s_tdata > LARGEST_SIZE) begin
                    ev         = EV_ERROR;
                    ev_sbytes  = '0;
                    phase_next = PH_HALT;
                end else begin
                    size_next  = s_tdata[SIZE_W-1:0];
                    entry_next = '0;
                    bcnt_next  = '0;
                    ev         = EV_HEADER;
                    ev_sbytes  = BASE_SECTOR << s_tdata[SIZE_W-1:0];
                    if (nsec_reg == '0) begin
                        ev_last    = 1'b1;
                        phase_next = PH_MODE;
                    end else begin
                        phase_next = PH_SECMAP;
                    end
                end
            end
            PH_SECMAP, PH_CYLMAP, PH_HEADMAP: begin
                emit = 1'b1;
                if (phase_reg == PH_SECMAP) begin
                    ev = EV_SECMAP;
                end else if (phase_reg == PH_CYLMAP) begin
                    ev = EV_CYLMAP;
                end else begin
                    ev = EV_HEADMAP;
                end
                if (entry_end) begin
                    entry_next = '0;
                    phase_next = map_follow;
                end else begin
                    entry_next = entry_reg + 8'd1;
                end
            end
            PH_TYPE: begin
                if (s_tdata == TYPE_ABSENT) begin
                    emit     = 1'b1;
                    ev       = EV_ABSENT;
                    ev_value = '0;
                    ev_last  = entry_end;
                    if (entry_end) begin
                        entry_next = '0;
                        phase_next = PH_MODE;
                    end else begin
                        entry_next = entry_reg + 8'd1;
                    end
                end else if (s_tdata == TYPE_FILL) begin
                    phase_next = PH_FILL;
                end else begin
                    bcnt_next  = '0;
                    phase_next = PH_DATA;
                end
            end
            PH_FILL: begin
                emit    = 1'b1;
                ev      = EV_FILL;
                ev_last = entry_end;
                if (entry_end) begin
                    entry_next = '0;
                    phase_next = PH_MODE;
                end else begin
                    entry_next = entry_reg + 8'd1;
                    phase_next = PH_TYPE;
                end
            end
            PH_DATA: begin
                emit      = 1'b1;
                ev        = EV_DATA;
                ev_offset = bcnt_reg;
                if (sector_end) begin
                    bcnt_next = '0;
                    ev_last   = entry_end;
                    if (entry_end) begin
                        entry_next = '0;
                        phase_next = PH_MODE;
                    end else begin
                        entry_next = entry_reg + 8'd1;
                        phase_next = PH_TYPE;
                    end
                end else begin
                    bcnt_next = bcnt_inc[OFFSET_W-1:0];
                end
            end
            default: begin
                // halted after an error: ignore input
                phase_next = phase_reg;
            end
        endcase
    end

    // parser state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_COMMENT;
            mode_reg   <= '0;
            cyl_reg    <= '0;
            hflags_reg <= '0;
            nsec_reg   <= '0;
            size_reg   <= '0;
            entry_reg  <= '0;
            bcnt_reg   <= '0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            mode_reg   <= mode_next;
            cyl_reg    <= cyl_next;
            hflags_reg <= hflags_next;
            nsec_reg   <= nsec_next;
            size_reg   <= size_next;
            entry_reg  <= entry_next;
            bcnt_reg   <= bcnt_next;
        end
    end

    // output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= emit;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // output word payload
    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            m_user_reg <= ev;
            m_last_reg <= ev_last;
            m_data_reg <= {(M_DATA_W - USED_W)'(0), ev_value, ev_offset, ev_index,
                           ev_sbytes, nsec_reg, hflags_reg[HEAD_W-1:0], cyl_reg,
                           mode_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = m_data_reg;

endmodule

@@ hdl/dimg_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dimg_checker
// Port-level checks on the result stream of the disk image track parser.
// ----------------------------------------------------------------------------
module dimg_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [dimg_pkg::M_DATA_W-1:0] m_tdata,
    input logic [dimg_pkg::EVENT_W-1:0]  m_tuser,
    input logic                          m_tlast
);
    import dimg_pkg::*;

    // a stalled word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast))
        else $error("result word changed while stalled");

    // no words straight out of reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result word valid after reset");

    // after an error word the parser is silent
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tuser == EV_ERROR |=> !m_tvalid)
        else $error("word after error event");

    // data byte offset stays inside its sector
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == EV_DATA |->
        {1'b0, m_tdata[OFFSET_LO +: OFFSET_W]} < m_tdata[SBYTES_LO +: SBYTES_W])
        else $error("data offset beyond sector size");

    // a header closes the track only when it has no sectors
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == EV_HEADER |->
        m_tlast == (m_tdata[COUNT_LO +: BYTE_W] == '0))
        else $error("header track end mismatch");

endmodule

bind disk_image_track_parser dimg_checker u_dimg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
